FILE: hw/rtl/tlssni_pkg.sv
// Shared types and constants for the TLS ClientHello server-name extractor.
`timescale 1ns / 1ps

package tlssni_pkg;

    // Final verdict codes; ST_NONE means that no verdict is held yet.
    typedef enum logic [2:0] {
        ST_INCOMPLETE = 3'd0,
        ST_NOT_TLS    = 3'd1,
        ST_MALFORMED  = 3'd2,
        ST_NO_SNI     = 3'd3,
        ST_FOUND      = 3'd4,
        ST_NONE       = 3'd7
    } status_t;

    // One result item as the parser produces it for a byte.
    typedef struct packed {
        logic       name_byte_valid;
        logic [7:0] name_byte;
        logic       status_valid;
        status_t    parse_status;
    } res_t;

    localparam logic [7:0]  CONTENT_HANDSHAKE = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME   = 16'h0000;
    localparam logic [7:0]  NAME_HOST         = 8'h00;
    localparam logic [15:0] FIXED_PART_LEN    = 16'd34;
    localparam logic [16:0] REC_HDR_LEN       = 17'd5;
    localparam logic [15:0] HS_HDR_LEN        = 16'd4;

endpackage

FILE: hw/rtl/tlssni_parser.sv
// Byte-wise ClientHello parser: phase register, length bookkeeping and result logic.
`timescale 1ns / 1ps

module tlssni_parser
    import tlssni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    output res_t       result
);

    typedef enum logic [4:0] {
        PH_REC, PH_HS_TYPE, PH_HS_LEN, PH_FIXED, PH_SID_LEN, PH_SID_SKIP,
        PH_CS_HI, PH_CS_LO, PH_CS_SKIP, PH_CM_LEN, PH_CM_SKIP,
        PH_EXTS_HI, PH_EXTS_LO, PH_EXT_T0, PH_EXT_T1,
        PH_SNI_L0, PH_SNI_L1, PH_OTH_L0, PH_OTH_L1, PH_EXT_SKIP,
        PH_LIST_HI, PH_LIST_LO, PH_NAME_TYPE, PH_HOST_L0, PH_HOST_L1,
        PH_OTHN_L0, PH_OTHN_L1, PH_NAME_SKIP, PH_NAME_EMIT, PH_DONE
    } phase_t;

    localparam logic [16:0] IDX_MAX = 17'h1FFFF;

    phase_t      phase_reg, phase_mid, phase_next;
    logic [16:0] idx_reg;
    logic [15:0] rl_reg, rl_next;
    logic [23:0] hl_reg, hl_next;
    logic [15:0] offset_reg, offset_mid;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] su_reg, su_next;
    logic [15:0] exl_reg, exl_next;
    logic [15:0] el_reg, el_next;
    logic [15:0] nl_reg, nl_next;
    status_t     vd_reg, vd_mid, vd_next;
    logic        sent_reg;

    logic [15:0] offset_inc;
    logic [15:0] word16;
    logic [16:0] sum_v;
    logic [15:0] skip_len;
    logic [16:0] skip_sum;
    logic [23:0] skip_bound;
    logic        skip_bad;
    logic [23:0] hl_shift;
    logic [15:0] rl_low;
    logic        settle_hit;
    logic        name_hit;
    logic        stat_hit;
    status_t     stat_code;

    // Operands shared by the one-byte body phases.
    always_comb
    begin
        offset_inc = offset_reg + 16'd1;
        word16     = {acc_reg[7:0], data_byte};
        sum_v      = {1'b0, offset_inc} + {1'b0, word16};
        hl_shift   = {hl_reg[15:0], data_byte};
        rl_low     = rl_reg | {8'd0, data_byte};
        case (phase_reg)
            PH_SID_LEN, PH_CM_LEN: skip_len = {8'd0, data_byte};
            default:               skip_len = word16;
        endcase
        case (phase_reg)
            PH_OTH_L1:  skip_bound = {8'd0, exl_reg};
            PH_OTHN_L1: skip_bound = {8'd0, nl_reg};
            default:    skip_bound = hl_reg;
        endcase
        skip_sum = {1'b0, offset_inc} + {1'b0, skip_len};
        skip_bad = {8'd0, skip_sum} > {1'b0, skip_bound};
    end

    always_comb
    begin
        phase_mid  = phase_reg;
        offset_mid = offset_reg;
        rl_next    = rl_reg;
        hl_next    = hl_reg;
        acc_next   = acc_reg;
        su_next    = su_reg;
        exl_next   = exl_reg;
        el_next    = el_reg;
        nl_next    = nl_reg;
        vd_mid     = vd_reg;
        name_hit   = 1'b0;
        stat_hit   = 1'b0;
        stat_code  = ST_INCOMPLETE;

        if (!sent_reg)
        begin
            case (phase_reg)
                PH_REC:
                begin
                    if (idx_reg == 17'd0 && data_byte != CONTENT_HANDSHAKE)
                    begin
                        vd_mid = ST_NOT_TLS;
                    end
                    if (idx_reg == 17'd3)
                    begin
                        rl_next = {data_byte, 8'd0};
                    end
                    if (idx_reg == 17'd4)
                    begin
                        rl_next = rl_low;
                        if (vd_reg == ST_NOT_TLS)
                        begin
                            stat_hit  = 1'b1;
                            stat_code = ST_NOT_TLS;
                            phase_mid = PH_DONE;
                        end
                        else if (rl_low < HS_HDR_LEN)
                        begin
                            vd_mid    = ST_MALFORMED;
                            phase_mid = PH_DONE;
                        end
                        else
                        begin
                            phase_mid = PH_HS_TYPE;
                        end
                    end
                end
                PH_HS_TYPE:
                begin
                    if (data_byte != HS_CLIENT_HELLO)
                    begin
                        vd_mid    = ST_NOT_TLS;
                        phase_mid = PH_DONE;
                    end
                    else
                    begin
                        phase_mid = PH_HS_LEN;
                    end
                end
                PH_HS_LEN:
                begin
                    hl_next = hl_shift;
                    if (idx_reg == 17'd8)
                    begin
                        if ({9'd0, HS_HDR_LEN} + {1'b0, hl_shift} > {9'd0, rl_reg})
                        begin
                            vd_mid    = ST_MALFORMED;
                            phase_mid = PH_DONE;
                        end
                        else
                        begin
                            offset_mid = 16'd0;
                            if ({8'd0, FIXED_PART_LEN} > hl_shift)
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                su_next   = FIXED_PART_LEN;
                                phase_mid = PH_FIXED;
                            end
                        end
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    offset_mid = offset_inc;
                    case (phase_reg)
                        PH_SID_LEN, PH_CS_LO, PH_CM_LEN, PH_OTH_L1, PH_OTHN_L1:
                        begin
                            if (skip_bad)
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                su_next = skip_sum[15:0];
                                case (phase_reg)
                                    PH_SID_LEN: phase_mid = PH_SID_SKIP;
                                    PH_CS_LO:   phase_mid = PH_CS_SKIP;
                                    PH_CM_LEN:  phase_mid = PH_CM_SKIP;
                                    PH_OTH_L1:  phase_mid = PH_EXT_SKIP;
                                    default:    phase_mid = PH_NAME_SKIP;
                                endcase
                            end
                        end
                        PH_CS_HI, PH_EXTS_HI, PH_EXT_T0, PH_SNI_L0,
                        PH_OTH_L0, PH_LIST_HI, PH_HOST_L0, PH_OTHN_L0:
                        begin
                            acc_next  = {8'd0, data_byte};
                            phase_mid = phase_t'(phase_reg + 5'd1);
                        end
                        PH_EXTS_LO:
                        begin
                            if ({8'd0, sum_v} > {1'b0, hl_reg})
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                exl_next = sum_v[15:0];
                                if ({1'b0, offset_inc} + 17'd4 <= sum_v)
                                begin
                                    phase_mid = PH_EXT_T0;
                                end
                                else
                                begin
                                    vd_mid    = ST_NO_SNI;
                                    phase_mid = PH_DONE;
                                end
                            end
                        end
                        PH_EXT_T1:
                        begin
                            phase_mid = (word16 == EXT_SERVER_NAME) ? PH_SNI_L0 : PH_OTH_L0;
                        end
                        PH_SNI_L1:
                        begin
                            if (sum_v > {1'b0, exl_reg})
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                el_next = sum_v[15:0];
                                if ({1'b0, offset_inc} + 17'd2 > sum_v)
                                begin
                                    vd_mid    = ST_MALFORMED;
                                    phase_mid = PH_DONE;
                                end
                                else
                                begin
                                    phase_mid = PH_LIST_HI;
                                end
                            end
                        end
                        PH_LIST_LO:
                        begin
                            if (sum_v > {1'b0, el_reg})
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                nl_next = sum_v[15:0];
                                if ({1'b0, offset_inc} + 17'd3 <= sum_v)
                                begin
                                    phase_mid = PH_NAME_TYPE;
                                end
                                else
                                begin
                                    vd_mid    = ST_NO_SNI;
                                    phase_mid = PH_DONE;
                                end
                            end
                        end
                        PH_NAME_TYPE:
                        begin
                            phase_mid = (data_byte == NAME_HOST) ? PH_HOST_L0 : PH_OTHN_L0;
                        end
                        PH_HOST_L1:
                        begin
                            if (sum_v > {1'b0, nl_reg})
                            begin
                                vd_mid    = ST_MALFORMED;
                                phase_mid = PH_DONE;
                            end
                            else
                            begin
                                vd_mid    = ST_FOUND;
                                su_next   = sum_v[15:0];
                                phase_mid = PH_NAME_EMIT;
                            end
                        end
                        PH_NAME_EMIT:
                        begin
                            name_hit = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    // A skip that has reached its end resolves without taking a byte. None of
    // the phases it leads to is a skip, so one resolution step is enough.
    always_comb
    begin
        phase_next = phase_mid;
        vd_next    = vd_mid;
        settle_hit = (offset_mid == su_next) && !sent_reg;
        if (settle_hit)
        begin
            case (phase_mid)
                PH_FIXED:
                begin
                    if ({9'd0, offset_mid} + 25'd1 > {1'b0, hl_next})
                    begin
                        vd_next    = ST_MALFORMED;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_SID_LEN;
                    end
                end
                PH_SID_SKIP:
                begin
                    if ({9'd0, offset_mid} + 25'd2 > {1'b0, hl_next})
                    begin
                        vd_next    = ST_MALFORMED;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CS_HI;
                    end
                end
                PH_CS_SKIP:
                begin
                    if ({9'd0, offset_mid} + 25'd1 > {1'b0, hl_next})
                    begin
                        vd_next    = ST_MALFORMED;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CM_LEN;
                    end
                end
                PH_CM_SKIP:
                begin
                    if ({8'd0, offset_mid} == hl_next)
                    begin
                        vd_next    = ST_NO_SNI;
                        phase_next = PH_DONE;
                    end
                    else if ({9'd0, offset_mid} + 25'd2 > {1'b0, hl_next})
                    begin
                        vd_next    = ST_MALFORMED;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_EXTS_HI;
                    end
                end
                PH_EXT_SKIP:
                begin
                    if ({1'b0, offset_mid} + 17'd4 <= {1'b0, exl_next})
                    begin
                        phase_next = PH_EXT_T0;
                    end
                    else
                    begin
                        vd_next    = ST_NO_SNI;
                        phase_next = PH_DONE;
                    end
                end
                PH_NAME_SKIP:
                begin
                    if ({1'b0, offset_mid} + 17'd3 <= {1'b0, nl_next})
                    begin
                        phase_next = PH_NAME_TYPE;
                    end
                    else
                    begin
                        vd_next    = ST_NO_SNI;
                        phase_next = PH_DONE;
                    end
                end
                PH_NAME_EMIT:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result for this byte: the status goes out at the header's last byte for a
    // non-handshake record, else at the record's last byte or the buffer end, whichever comes first.
    always_comb
    begin
        result.name_byte_valid = name_hit;
        result.name_byte       = name_hit ? data_byte : 8'd0;
        result.status_valid    = 1'b0;
        result.parse_status    = ST_INCOMPLETE;
        if (!sent_reg)
        begin
            if (stat_hit)
            begin
                result.status_valid = 1'b1;
                result.parse_status = stat_code;
            end
            else if (idx_reg == REC_HDR_LEN - 17'd1 + {1'b0, rl_next})
            begin
                result.status_valid = 1'b1;
                result.parse_status = (logic'(vd_next) == 1'b0 ||
                                       3'(vd_next) <= 3'(ST_FOUND)) ? vd_next : ST_MALFORMED;
            end
            else if (end_of_buffer)
            begin
                result.status_valid = 1'b1;
                result.parse_status = ST_INCOMPLETE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_REC;
            idx_reg    <= 17'd0;
            rl_reg     <= 16'd0;
            hl_reg     <= 24'd0;
            offset_reg <= 16'd0;
            acc_reg    <= 16'd0;
            su_reg     <= 16'd0;
            exl_reg    <= 16'd0;
            el_reg     <= 16'd0;
            nl_reg     <= 16'd0;
            vd_reg     <= ST_NONE;
            sent_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            if (end_of_buffer)
            begin
                phase_reg  <= PH_REC;
                idx_reg    <= 17'd0;
                rl_reg     <= 16'd0;
                hl_reg     <= 24'd0;
                offset_reg <= 16'd0;
                acc_reg    <= 16'd0;
                su_reg     <= 16'd0;
                exl_reg    <= 16'd0;
                el_reg     <= 16'd0;
                nl_reg     <= 16'd0;
                vd_reg     <= ST_NONE;
                sent_reg   <= 1'b0;
            end
            else if (!sent_reg)
            begin
                phase_reg  <= phase_next;
                idx_reg    <= (idx_reg != IDX_MAX) ? idx_reg + 17'd1 : idx_reg;
                rl_reg     <= rl_next;
                hl_reg     <= hl_next;
                offset_reg <= offset_mid;
                acc_reg    <= acc_next;
                su_reg     <= su_next;
                exl_reg    <= exl_next;
                el_reg     <= el_next;
                nl_reg     <= nl_next;
                vd_reg     <= vd_next;
                sent_reg   <= result.status_valid;
            end
        end
    end

    a_quiet_after_status: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg && step_en |-> !result.name_byte_valid && !result.status_valid)
        else $error("result produced after the final status");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && end_of_buffer |=> phase_reg == PH_REC && idx_reg == 17'd0 && !sent_reg)
        else $error("parser did not restart after the buffer end");

    a_name_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result.name_byte_valid |-> phase_reg == PH_NAME_EMIT && !sent_reg)
        else $error("name byte outside the host name field");

    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && end_of_buffer && !sent_reg |-> result.status_valid)
        else $error("buffer ended without a status");

endmodule

FILE: hw/rtl/tlssni_out_stage.sv
// Output register stage that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module tlssni_out_stage
    import tlssni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       result,
    input  logic       out_ready,
    output logic       can_load,
    output logic       out_valid,
    output logic [7:0] name_byte,
    output logic       name_byte_valid,
    output logic [2:0] parse_status,
    output logic       status_valid
);

    logic valid_reg;
    res_t data_reg;
    logic has_item;

    assign has_item = result.name_byte_valid || result.status_valid;
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load && has_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid       = valid_reg;
    assign name_byte       = data_reg.name_byte;
    assign name_byte_valid = data_reg.name_byte_valid;
    assign parse_status    = 3'(data_reg.parse_status);
    assign status_valid    = data_reg.status_valid;

endmodule

FILE: hw/rtl/tls_client_hello_sni_extractor_unit.sv
// Top level of the TLS ClientHello server-name extractor.
//
// Input channel (in_valid/in_ready): one byte of a captured buffer per
// transfer, with end_of_buffer set on its last byte. Output channel
// (out_valid/out_ready): a result transfer carries a host name byte
// (name_byte_valid), the final status of the buffer (status_valid), or both.
// Bytes that cause no result produce no output transfer.
// A byte is taken into an input register at its transfer and parsed from
// there. Its result is loaded into the output register when the parse
// step runs, and out_valid rises with it; the parse step waits while the
// output register holds a result that the receiver has not taken.
// One byte per cycle is sustained while the receiver does not stall: the
// phase and length registers of the parser close their loop within each byte's parse step.
// Reset clears the parser to the start of a record and empties both stages.
// When the receiver stalls, the output register holds its result, the parse
// step waits, and in_ready drops as soon as the input register holds a byte.
// After the status, bytes are dropped until end_of_buffer, which restarts
// the parser for the next buffer.
`timescale 1ns / 1ps

module tls_client_hello_sni_extractor_unit
    import tlssni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] name_byte,
    output logic       name_byte_valid,
    output logic [2:0] parse_status,
    output logic       status_valid
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       eob_reg;
    logic       can_load;
    logic       step_en;
    res_t       result;

    assign step_en  = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            eob_reg  <= end_of_buffer;
        end
    end

    tlssni_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .data_byte     (byte_reg),
        .end_of_buffer (eob_reg),
        .result        (result)
    );

    tlssni_out_stage u_out_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (step_en),
        .result          (result),
        .out_ready       (out_ready),
        .can_load        (can_load),
        .out_valid       (out_valid),
        .name_byte       (name_byte),
        .name_byte_valid (name_byte_valid),
        .parse_status    (parse_status),
        .status_valid    (status_valid)
    );

endmodule
